// ===== hw/rtl/gpm_pkg.sv =====
// Shared types, codes and helpers of the gyro peak motion classifier.
package gpm_pkg;

   localparam int RATE_W  = 16;
   localparam int MAG_W   = 17;
   localparam int SQ_W    = 31;
   localparam int TIME_W  = 32;
   localparam int CLASS_W = 3;
   localparam int CSR_W   = 16;
   localparam int INDEX_W = 3;

   localparam logic [TIME_W-1:0] QUIET_MS = 32'd80;

   // Result codes.
   localparam logic [CLASS_W-1:0] CLASS_NONE     = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_OLLIE    = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_KICKFLIP = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_HEELFLIP = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_BS_SHUV  = 3'd4;
   localparam logic [CLASS_W-1:0] CLASS_FS_SHUV  = 3'd5;

   // Register indexes.
   localparam logic [INDEX_W-1:0] CSR_FLIP_MIN   = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_FLIP_RATIO = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_PITCH_MIN  = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_YAW_MIN    = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_YAW_RATIO  = 3'd4;
   localparam logic [INDEX_W-1:0] CSR_ACTIVE_MIN = 3'd5;
   localparam logic [INDEX_W-1:0] CSR_HOLD_MS    = 3'd6;
   localparam logic [INDEX_W-1:0] CSR_WINDOW_MS  = 3'd7;

   typedef struct packed {
      logic [15:0] flip_min;
      logic [9:0]  flip_ratio;
      logic [15:0] pitch_min;
      logic [15:0] yaw_min;
      logic [9:0]  yaw_ratio;
      logic [15:0] active_min;
      logic [15:0] hold_ms;
      logic [15:0] window_ms;
   } gpm_cfg_type;

   // One sample as it reaches the tracking stage.
   typedef struct packed {
      logic signed [RATE_W-1:0] roll;
      logic signed [RATE_W-1:0] pitch;
      logic signed [RATE_W-1:0] yaw;
      logic [MAG_W-1:0]         roll_mag;
      logic [MAG_W-1:0]         pitch_mag;
      logic [MAG_W-1:0]         yaw_mag;
      logic                     active;
      logic [TIME_W-1:0]        time_ms;
   } gpm_item_type;

   // Absolute value; full-scale negative gives 32768.
   function automatic logic [MAG_W-1:0] mag16(input logic signed [RATE_W-1:0] v);
      logic signed [MAG_W-1:0] ext;
      ext = {v[RATE_W-1], v};
      return v[RATE_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
   endfunction

endpackage

// ===== hw/rtl/gpm_lane.sv =====
// One axis lane: magnitude and square, then a second stage that carries the sample.
module gpm_lane
   import gpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     s1_load,
   input  logic                     s2_load,
   input  logic signed [RATE_W-1:0] rate,
   output logic [SQ_W-1:0]          lane_sq,
   output logic signed [RATE_W-1:0] lane_rate,
   output logic [MAG_W-1:0]         lane_mag
);

   logic signed [RATE_W-1:0] s1_rate_ff;
   logic [MAG_W-1:0]         s1_mag_ff;
   logic [SQ_W-1:0]          s1_sq_ff;
   logic signed [RATE_W-1:0] s2_rate_ff;
   logic [MAG_W-1:0]         s2_mag_ff;
   logic [MAG_W-1:0]         mag;
   logic [2*MAG_W-1:0]       sq_full;

   assign mag     = mag16(rate);
   assign sq_full = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_rate_ff <= rate;
         s1_mag_ff  <= mag;
         s1_sq_ff   <= sq_full[SQ_W-1:0];
      end
      if (s2_load) begin
         s2_rate_ff <= s1_rate_ff;
         s2_mag_ff  <= s1_mag_ff;
      end
   end

   assign lane_sq   = s1_sq_ff;
   assign lane_rate = s2_rate_ff;
   assign lane_mag  = s2_mag_ff;

endmodule

// ===== hw/rtl/gpm_merge.sv =====
// Merges the three lane squares into the activity decision.
module gpm_merge
   import gpm_pkg::*;
(
   input  logic              clock,
   input  logic              s2_load,
   input  logic [15:0]       active_min,
   input  logic [SQ_W-1:0]   sq_roll,
   input  logic [SQ_W-1:0]   sq_pitch,
   input  logic [SQ_W-1:0]   sq_yaw,
   output logic              active
);

   logic [31:0] thr_ff;
   logic        active_ff;
   logic [32:0] sum;

   // Change the threshold only while idle (unenforced): its square is registered.
   always_ff @(posedge clock) begin
      thr_ff <= 32'(active_min) * 32'(active_min);
      if (s2_load) begin
         active_ff <= sum > {1'b0, thr_ff};
      end
   end

   assign sum    = 33'(sq_roll) + 33'(sq_pitch) + 33'(sq_yaw);
   assign active = active_ff;

endmodule

// ===== hw/rtl/gpm_track.sv =====
// Window, peak and hold tracking with trick classification; drives the result register.
module gpm_track
   import gpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               commit,
   input  gpm_item_type       item,
   input  gpm_cfg_type        cfg,
   output logic [CLASS_W-1:0] motion_class,
   output logic               fresh
);

   logic signed [RATE_W-1:0] roll_peak_ff, pitch_peak_ff, yaw_peak_ff;
   logic signed [RATE_W-1:0] roll_peak_in, pitch_peak_in, yaw_peak_in;
   logic                     window_open_ff, window_open_in;
   logic [TIME_W-1:0]        window_start_ff, window_start_in;
   logic [TIME_W-1:0]        last_active_ff, last_active_in;
   logic                     hold_active_ff, hold_active_in;
   logic [TIME_W-1:0]        hold_start_ff, hold_start_in;
   logic [CLASS_W-1:0]       held_class_ff, held_class_in;
   logic [CLASS_W-1:0]       class_ff, class_in;
   logic                     fresh_ff, fresh_in;

   logic                     hold_busy;
   logic signed [RATE_W-1:0] roll_eff, pitch_eff, yaw_eff;
   logic [TIME_W-1:0]        start_eff, last_eff;
   logic                     open_eff, quiet, done;
   logic [MAG_W-1:0]         fp, op, sp;
   logic [26:0]              yaw_prod, flip_prod;
   logic [CLASS_W-1:0]       cls;

   assign hold_busy = hold_active_ff &&
                      ((item.time_ms - hold_start_ff) < TIME_W'(cfg.hold_ms));

   // Peaks, window start and last activity as they stand after this sample.
   always_comb begin
      roll_eff  = roll_peak_ff;
      pitch_eff = pitch_peak_ff;
      yaw_eff   = yaw_peak_ff;
      if (item.active) begin
         if (item.roll_mag > mag16(roll_peak_ff))   roll_eff  = item.roll;
         if (item.pitch_mag > mag16(pitch_peak_ff)) pitch_eff = item.pitch;
         if (item.yaw_mag > mag16(yaw_peak_ff))     yaw_eff   = item.yaw;
      end
   end

   assign open_eff  = window_open_ff || item.active;
   assign start_eff = (item.active && !window_open_ff) ? item.time_ms : window_start_ff;
   assign last_eff  = item.active ? item.time_ms : last_active_ff;
   assign quiet     = !item.active && ((item.time_ms - last_eff) >= QUIET_MS);
   assign done      = (item.time_ms - start_eff) >= TIME_W'(cfg.window_ms);

   assign fp        = mag16(roll_eff);
   assign op        = mag16(pitch_eff);
   assign sp        = mag16(yaw_eff);
   assign yaw_prod  = 27'(op) * 27'(cfg.yaw_ratio);
   assign flip_prod = 27'(op) * 27'(cfg.flip_ratio);

   always_comb begin
      if (sp >= MAG_W'(cfg.yaw_min) && fp < MAG_W'(cfg.flip_min) &&
          27'({sp, 8'b0}) >= yaw_prod) begin
         cls = (yaw_eff > 0) ? CLASS_BS_SHUV : CLASS_FS_SHUV;
      end else if (fp >= MAG_W'(cfg.flip_min) && 27'({fp, 8'b0}) >= flip_prod) begin
         cls = (roll_eff > 0) ? CLASS_KICKFLIP : CLASS_HEELFLIP;
      end else if (op >= MAG_W'(cfg.pitch_min)) begin
         cls = CLASS_OLLIE;
      end else begin
         cls = CLASS_NONE;
      end
   end

   always_comb begin
      roll_peak_in    = roll_peak_ff;
      pitch_peak_in   = pitch_peak_ff;
      yaw_peak_in     = yaw_peak_ff;
      window_open_in  = window_open_ff;
      window_start_in = window_start_ff;
      last_active_in  = last_active_ff;
      hold_active_in  = hold_active_ff;
      hold_start_in   = hold_start_ff;
      held_class_in   = held_class_ff;
      class_in        = CLASS_NONE;
      fresh_in        = 1'b0;
      if (hold_busy) begin
         // The sample is dropped while a detected class is held.
         class_in = held_class_ff;
      end else begin
         hold_active_in  = 1'b0;
         roll_peak_in    = roll_eff;
         pitch_peak_in   = pitch_eff;
         yaw_peak_in     = yaw_eff;
         window_open_in  = open_eff;
         window_start_in = start_eff;
         last_active_in  = last_eff;
         if (open_eff && (quiet || done)) begin
            held_class_in   = cls;
            roll_peak_in    = '0;
            pitch_peak_in   = '0;
            yaw_peak_in     = '0;
            window_open_in  = 1'b0;
            window_start_in = '0;
            last_active_in  = '0;
            if (cls != CLASS_NONE) begin
               hold_active_in = 1'b1;
               hold_start_in  = item.time_ms;
               class_in       = cls;
               fresh_in       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_peak_ff    <= '0;
         pitch_peak_ff   <= '0;
         yaw_peak_ff     <= '0;
         window_open_ff  <= 1'b0;
         window_start_ff <= '0;
         last_active_ff  <= '0;
         hold_active_ff  <= 1'b0;
         hold_start_ff   <= '0;
         held_class_ff   <= CLASS_NONE;
      end else if (commit) begin
         roll_peak_ff    <= roll_peak_in;
         pitch_peak_ff   <= pitch_peak_in;
         yaw_peak_ff     <= yaw_peak_in;
         window_open_ff  <= window_open_in;
         window_start_ff <= window_start_in;
         last_active_ff  <= last_active_in;
         hold_active_ff  <= hold_active_in;
         hold_start_ff   <= hold_start_in;
         held_class_ff   <= held_class_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         class_ff <= class_in;
         fresh_ff <= fresh_in;
      end
   end

   assign motion_class = class_ff;
   assign fresh        = fresh_ff;

endmodule

// ===== hw/rtl/gyro_peak_motion_classifier.sv =====
// Top level of the gyro peak motion classifier: lanes, merge, tracking and register file.
//
// The req_ channel carries one gyro sample per beat (roll, pitch and yaw rate in
// raw signed counts plus a millisecond timestamp); the rsp_ channel returns exactly
// one beat per sample with the motion class and a fresh flag that marks a newly
// detected trick. Both channels use valid/ready.
// Registers are written through csr_write_enable, csr_index and csr_data, only
// while no sample is in flight; the user must ensure this, the block does not.
// A sample passes the stage 1 lane registers, the stage 2 lane and merge registers
// and the tracking result register before rsp_valid rises. Throughput is one
// sample per cycle while rsp is not stalled: three axis lanes square in parallel,
// the merge stage sums the squares against the squared threshold, and the
// tracking stage updates the peaks, window and hold for one sample per cycle.
// Each stage has its own valid bit, so a stalled rsp beat only blocks the
// stages behind it once they fill; up to three samples are held in flight.
// A synchronous reset empties the pipeline, clears the window, peaks and hold,
// and loads the register defaults; req_ready is low while reset is high.
module gyro_peak_motion_classifier
   import gpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [RATE_W-1:0] req_roll_rate,
   input  logic signed [RATE_W-1:0] req_pitch_rate,
   input  logic signed [RATE_W-1:0] req_yaw_rate,
   input  logic [TIME_W-1:0]        req_time_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CLASS_W-1:0]       rsp_motion_class,
   output logic                     rsp_fresh,
   input  logic                     csr_write_enable,
   input  logic [INDEX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]         csr_data
);

   gpm_cfg_type       cfg_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic              s2_valid_ff, s2_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] s1_time_ff, s2_time_ff;
   logic              out_ready, s2_ready, s1_ready;
   logic              req_fire, s1_adv, s2_adv;
   logic [SQ_W-1:0]   sq_roll, sq_pitch, sq_yaw;
   gpm_item_type      item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flip_min   <= 16'd14410;
         cfg_ff.flip_ratio <= 10'd346;
         cfg_ff.pitch_min  <= 16'd9825;
         cfg_ff.yaw_min    <= 16'd11135;
         cfg_ff.yaw_ratio  <= 10'd320;
         cfg_ff.active_min <= 16'd4585;
         cfg_ff.hold_ms    <= 16'd400;
         cfg_ff.window_ms  <= 16'd480;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FLIP_MIN:   cfg_ff.flip_min   <= csr_data;
            CSR_FLIP_RATIO: cfg_ff.flip_ratio <= csr_data[9:0];
            CSR_PITCH_MIN:  cfg_ff.pitch_min  <= csr_data;
            CSR_YAW_MIN:    cfg_ff.yaw_min    <= csr_data;
            CSR_YAW_RATIO:  cfg_ff.yaw_ratio  <= csr_data[9:0];
            CSR_ACTIVE_MIN: cfg_ff.active_min <= csr_data;
            CSR_HOLD_MS:    cfg_ff.hold_ms    <= csr_data;
            CSR_WINDOW_MS:  cfg_ff.window_ms  <= csr_data;
            default: ;
         endcase
      end
   end

   // Per-stage flow control: a stage can load when it is empty or moving on.
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready && !reset;
   assign req_fire  = req_valid && req_ready;
   assign s1_adv    = s1_valid_ff && s2_ready;
   assign s2_adv    = s2_valid_ff && out_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s2_ready);
   assign s2_valid_in  = s1_adv || (s2_valid_ff && !out_ready);
   assign rsp_valid_in = s2_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) s1_time_ff <= req_time_ms;
      if (s1_adv)   s2_time_ff <= s1_time_ff;
   end

   gpm_lane u_lane_roll (
      .clock     (clock),
      .s1_load   (req_fire),
      .s2_load   (s1_adv),
      .rate      (req_roll_rate),
      .lane_sq   (sq_roll),
      .lane_rate (item.roll),
      .lane_mag  (item.roll_mag)
   );

   gpm_lane u_lane_pitch (
      .clock     (clock),
      .s1_load   (req_fire),
      .s2_load   (s1_adv),
      .rate      (req_pitch_rate),
      .lane_sq   (sq_pitch),
      .lane_rate (item.pitch),
      .lane_mag  (item.pitch_mag)
   );

   gpm_lane u_lane_yaw (
      .clock     (clock),
      .s1_load   (req_fire),
      .s2_load   (s1_adv),
      .rate      (req_yaw_rate),
      .lane_sq   (sq_yaw),
      .lane_rate (item.yaw),
      .lane_mag  (item.yaw_mag)
   );

   gpm_merge u_merge (
      .clock      (clock),
      .s2_load    (s1_adv),
      .active_min (cfg_ff.active_min),
      .sq_roll    (sq_roll),
      .sq_pitch   (sq_pitch),
      .sq_yaw     (sq_yaw),
      .active     (item.active)
   );

   assign item.time_ms = s2_time_ff;

   gpm_track u_track (
      .clock        (clock),
      .reset        (reset),
      .commit       (s2_adv),
      .item         (item),
      .cfg          (cfg_ff),
      .motion_class (rsp_motion_class),
      .fresh        (rsp_fresh)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/gpm_checker.sv =====
// Port-level checks of the gyro peak motion classifier and their bind.
module gpm_checker
   import gpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [CLASS_W-1:0] rsp_motion_class,
   input  logic               rsp_fresh
);

   // A fresh beat always carries a detected trick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fresh |-> rsp_motion_class != CLASS_NONE)
      else $error("fresh result without a trick class");

   // Only the six defined class codes ever leave the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_motion_class <= CLASS_FS_SHUV)
      else $error("undefined motion class code");

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_motion_class) &&
                                  $stable(rsp_fresh))
      else $error("stalled result beat changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind gyro_peak_motion_classifier gpm_checker u_gpm_checker (.*);
